// ===== rtl/lslf_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, types and status codes for the least-squares line fit
// no dependencies

package lslf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_POINTS  = 4096;
  localparam int FRAC_W      = 16;
  localparam int OUT_W       = 48;
  localparam int STATUS_W    = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam int LOG_N  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SX_W   = SAMPLE_BITS + LOG_N;
  localparam int SXY_W  = 2 * SAMPLE_BITS + LOG_N;
  localparam int SXX_W  = 2 * SAMPLE_BITS - 1 + LOG_N;
  localparam int MAG_W  = 2 * SAMPLE_BITS - 1 + LOG_N;
  localparam int TERM_W = 3 * SAMPLE_BITS + 2 * LOG_N;
  localparam int DEN_W  = 2 * SAMPLE_BITS - 1 + 2 * LOG_N;
  localparam int NUM_W  = TERM_W - 1 + FRAC_W;
  localparam int STEP_W = $clog2(NUM_W);

  typedef logic        [CNT_W-1:0] cnt_t;
  typedef logic signed [SX_W-1:0]  sx_t;
  typedef logic signed [SXY_W-1:0] sxy_t;
  typedef logic        [SXX_W-1:0] sxx_t;

  typedef struct packed {
    cnt_t cnt;
    sx_t  sx;
    sx_t  sy;
    sxy_t sxy;
    sxx_t sxx;
    logic ovf;
  } snap_t;

  typedef enum logic [STATUS_W-1:0] {
    FIT_OK       = 2'd0,
    FIT_ZERO_VAR = 2'd1,
    FIT_OVERFLOW = 2'd2
  } fit_status_t;

endpackage

// ===== rtl/lslf_accum.sv =====
`timescale 1ns / 1ps
// front end: takes one point per cycle while the queue has room and keeps exact running sums
// depends on lslf_pkg; hands finished sets to lslf_queue

module lslf_accum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lslf_pkg::SAMPLE_W-1:0] in_x_value,
  input  logic [lslf_pkg::SAMPLE_W-1:0] in_y_value,
  input  logic                          in_last_point,
  input  logic                          q_ready,
  output logic                          q_push,
  output lslf_pkg::snap_t               q_wdata
);
  import lslf_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0]   smp_t;
  typedef logic signed [2*SAMPLE_BITS-1:0] smp_prod_t;

  cnt_t      cnt_r, cnt_nxt;
  sx_t       sx_r, sx_nxt;
  sx_t       sy_r, sy_nxt;
  sxy_t      sxy_r, sxy_nxt;
  sxx_t      sxx_r, sxx_nxt;
  logic      ovf_r, ovf_nxt;
  smp_t      x_s, y_s;
  smp_prod_t xy, xx;
  logic      take;
  logic      room;

  assign x_s  = $signed(SAMPLE_BITS'(in_x_value));
  assign y_s  = $signed(SAMPLE_BITS'(in_y_value));
  assign xy   = x_s * y_s;
  assign xx   = x_s * x_s;
  assign room = cnt_r < CNT_W'(MAX_POINTS);

  assign in_ready = q_ready;
  assign take     = in_valid && q_ready;
  assign q_push   = take && in_last_point;

  always_comb begin
    cnt_nxt = cnt_r;
    sx_nxt  = sx_r;
    sy_nxt  = sy_r;
    sxy_nxt = sxy_r;
    sxx_nxt = sxx_r;
    ovf_nxt = ovf_r;
    if (room) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      sx_nxt  = sx_r + sx_t'(x_s);
      sy_nxt  = sy_r + sx_t'(y_s);
      sxy_nxt = sxy_r + sxy_t'(xy);
      sxx_nxt = sxx_r + sxx_t'(xx);
    end else begin
      ovf_nxt = 1'b1;
    end
  end

  always_comb begin
    q_wdata.cnt = cnt_nxt;
    q_wdata.sx  = sx_nxt;
    q_wdata.sy  = sy_nxt;
    q_wdata.sxy = sxy_nxt;
    q_wdata.sxx = sxx_nxt;
    q_wdata.ovf = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxy_r <= '0;
      sxx_r <= '0;
      ovf_r <= 1'b0;
    end else if (take) begin
      if (in_last_point) begin
        cnt_r <= '0;
        sx_r  <= '0;
        sy_r  <= '0;
        sxy_r <= '0;
        sxx_r <= '0;
        ovf_r <= 1'b0;
      end else begin
        cnt_r <= cnt_nxt;
        sx_r  <= sx_nxt;
        sy_r  <= sy_nxt;
        sxy_r <= sxy_nxt;
        sxx_r <= sxx_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end

endmodule

// ===== rtl/lslf_queue.sv =====
`timescale 1ns / 1ps
// short queue of finished point sets between front and back end
// depends on lslf_pkg

module lslf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lslf_pkg::snap_t wdata,
  output logic            ready,
  input  logic            pop,
  output logic            valid,
  output lslf_pkg::snap_t rdata
);
  import lslf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  snap_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic              do_push, do_pop;

  assign ready   = fill_r != FILL_W'(QUEUE_DEPTH);
  assign valid   = fill_r != '0;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - FILL_W'(1);
      end
    end
  end

endmodule

// ===== rtl/lslf_solve.sv =====
`timescale 1ns / 1ps
// back end: serial shift-add multiplier and restoring divider under one
// sequencer, forming slope and intercept from a set of sums; depends on lslf_pkg

module lslf_solve (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  lslf_pkg::snap_t               q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lslf_pkg::OUT_W-1:0]    out_slope,
  output logic [lslf_pkg::OUT_W-1:0]    out_intercept,
  output logic [lslf_pkg::STATUS_W-1:0] out_fit_status
);
  import lslf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MLOAD = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_MACC  = 8'b0000_1000,
    S_DLOAD = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_DEND  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    P_N_SXX  = 3'd0,
    P_SX_SX  = 3'd1,
    P_N_SXY  = 3'd2,
    P_SX_SY  = 3'd3,
    P_SXX_SY = 3'd4,
    P_SX_SXY = 3'd5
  } prod_sel_t;

  typedef logic signed [MAG_W:0]    opnd_t;
  typedef logic signed [TERM_W-1:0] term_t;

  state_t            state_r, state_nxt;
  snap_t             snap_r, snap_nxt;
  prod_sel_t         psel_r, psel_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [MAG_W-1:0]  mcand_r, mcand_nxt;
  logic [2*MAG_W-1:0] prod_r, prod_nxt;
  logic              pneg_r, pneg_nxt;
  term_t             acc_r, acc_nxt;
  term_t             sn_r, sn_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic              dsel_r, dsel_nxt;
  logic              dneg_r, dneg_nxt;
  logic [NUM_W-1:0]  dq_r, dq_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [OUT_W-1:0]  slope_r, slope_nxt;
  logic [OUT_W-1:0]  icpt_r, icpt_nxt;
  fit_status_t       status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_slope_r, out_slope_nxt;
  logic [OUT_W-1:0]  out_icpt_r, out_icpt_nxt;
  fit_status_t       out_status_r, out_status_nxt;

  opnd_t             opa, opb;
  logic              op_sub;
  opnd_t             amag_s, bmag_s;
  logic [MAG_W:0]    madd;
  term_t             pmag, delta, acc_sum;
  term_t             num, nabs;
  logic [DEN_W:0]    trial;
  logic [DEN_W+1:0]  diff;
  logic              borrow;

  function automatic logic [OUT_W-1:0] q16_sat(input logic [NUM_W-1:0] q, input logic neg);
    logic             hi_nz;
    logic             is_min;
    logic [OUT_W-1:0] mag;
    hi_nz  = |q[NUM_W-1:OUT_W-1];
    is_min = q == (NUM_W'(1) << (OUT_W - 1));
    if (hi_nz && !(neg && is_min)) begin
      mag = neg ? (OUT_W'(1) << (OUT_W - 1)) : ~(OUT_W'(1) << (OUT_W - 1));
    end else begin
      mag = q[OUT_W-1:0];
    end
    q16_sat = neg ? (~mag + OUT_W'(1)) : mag;
  endfunction

  // operand pairs of the six products
  always_comb begin
    opa    = '0;
    opb    = '0;
    op_sub = 1'b0;
    case (psel_r)
      P_N_SXX: begin
        opa = opnd_t'(snap_r.cnt);
        opb = opnd_t'(snap_r.sxx);
      end
      P_SX_SX: begin
        opa    = opnd_t'($signed(snap_r.sx));
        opb    = opnd_t'($signed(snap_r.sx));
        op_sub = 1'b1;
      end
      P_N_SXY: begin
        opa = opnd_t'(snap_r.cnt);
        opb = opnd_t'($signed(snap_r.sxy));
      end
      P_SX_SY: begin
        opa    = opnd_t'($signed(snap_r.sx));
        opb    = opnd_t'($signed(snap_r.sy));
        op_sub = 1'b1;
      end
      P_SXX_SY: begin
        opa = opnd_t'(snap_r.sxx);
        opb = opnd_t'($signed(snap_r.sy));
      end
      P_SX_SXY: begin
        opa    = opnd_t'($signed(snap_r.sx));
        opb    = opnd_t'($signed(snap_r.sxy));
        op_sub = 1'b1;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign amag_s = opa[MAG_W] ? -opa : opa;
  assign bmag_s = opb[MAG_W] ? -opb : opb;

  assign madd = prod_r[0] ? ({1'b0, prod_r[2*MAG_W-1:MAG_W]} + {1'b0, mcand_r})
                          : {1'b0, prod_r[2*MAG_W-1:MAG_W]};

  assign pmag    = term_t'(prod_r[TERM_W-1:0]);
  assign delta   = (pneg_r ^ op_sub) ? -pmag : pmag;
  assign acc_sum = (op_sub ? acc_r : term_t'(0)) + delta;

  assign num  = dsel_r ? acc_r : sn_r;
  assign nabs = num[TERM_W-1] ? -num : num;

  assign trial  = {rem_r, dq_r[NUM_W-1]};
  assign diff   = {1'b0, trial} - {2'b00, den_r};
  assign borrow = diff[DEN_W+1];

  always_comb begin
    state_nxt      = state_r;
    snap_nxt       = snap_r;
    psel_nxt       = psel_r;
    step_nxt       = step_r;
    mcand_nxt      = mcand_r;
    prod_nxt       = prod_r;
    pneg_nxt       = pneg_r;
    acc_nxt        = acc_r;
    sn_nxt         = sn_r;
    den_nxt        = den_r;
    dsel_nxt       = dsel_r;
    dneg_nxt       = dneg_r;
    dq_nxt         = dq_r;
    rem_nxt        = rem_r;
    slope_nxt      = slope_r;
    icpt_nxt       = icpt_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_slope_nxt  = out_slope_r;
    out_icpt_nxt   = out_icpt_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          snap_nxt = q_data;
          if (q_data.ovf) begin
            slope_nxt  = '0;
            icpt_nxt   = '0;
            status_nxt = FIT_OVERFLOW;
            state_nxt  = S_OUT;
          end else begin
            psel_nxt  = P_N_SXX;
            state_nxt = S_MLOAD;
          end
        end
      end
      S_MLOAD: begin
        mcand_nxt = amag_s[MAG_W-1:0];
        prod_nxt  = {{MAG_W{1'b0}}, bmag_s[MAG_W-1:0]};
        pneg_nxt  = opa[MAG_W] ^ opb[MAG_W];
        step_nxt  = STEP_W'(MAG_W - 1);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt = {madd, prod_r[MAG_W-1:1]};
        if (step_r == '0) begin
          state_nxt = S_MACC;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_MACC: begin
        acc_nxt   = acc_sum;
        psel_nxt  = prod_sel_t'(psel_r + 3'd1);
        state_nxt = S_MLOAD;
        case (psel_r)
          P_SX_SX: begin
            den_nxt = acc_sum[DEN_W-1:0];
            if (acc_sum == '0) begin
              slope_nxt  = '0;
              icpt_nxt   = '0;
              status_nxt = FIT_ZERO_VAR;
              state_nxt  = S_OUT;
            end
          end
          P_SX_SY: begin
            sn_nxt = acc_sum;
          end
          P_SX_SXY: begin
            dsel_nxt  = 1'b0;
            state_nxt = S_DLOAD;
          end
          default: begin
            den_nxt = den_r;
          end
        endcase
      end
      S_DLOAD: begin
        dneg_nxt  = num[TERM_W-1];
        dq_nxt    = {nabs[TERM_W-2:0], {FRAC_W{1'b0}}};
        rem_nxt   = '0;
        step_nxt  = STEP_W'(NUM_W - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = borrow ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
        dq_nxt  = {dq_r[NUM_W-2:0], !borrow};
        if (step_r == '0) begin
          state_nxt = S_DEND;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      S_DEND: begin
        if (!dsel_r) begin
          slope_nxt = q16_sat(dq_r, dneg_r);
          dsel_nxt  = 1'b1;
          state_nxt = S_DLOAD;
        end else begin
          icpt_nxt   = q16_sat(dq_r, dneg_r);
          status_nxt = FIT_OK;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_slope_nxt  = slope_r;
          out_icpt_nxt   = icpt_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    snap_r       <= snap_nxt;
    psel_r       <= psel_nxt;
    step_r       <= step_nxt;
    mcand_r      <= mcand_nxt;
    prod_r       <= prod_nxt;
    pneg_r       <= pneg_nxt;
    acc_r        <= acc_nxt;
    sn_r         <= sn_nxt;
    den_r        <= den_nxt;
    dsel_r       <= dsel_nxt;
    dneg_r       <= dneg_nxt;
    dq_r         <= dq_nxt;
    rem_r        <= rem_nxt;
    slope_r      <= slope_nxt;
    icpt_r       <= icpt_nxt;
    status_r     <= status_nxt;
    out_slope_r  <= out_slope_nxt;
    out_icpt_r   <= out_icpt_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_slope      = out_slope_r;
  assign out_intercept  = out_icpt_r;
  assign out_fit_status = out_status_r;

endmodule

// ===== rtl/least_squares_line_fit.sv =====
`timescale 1ns / 1ps
// top level of the least-squares line fit: accumulator, set queue and solver
// depends on lslf_pkg, lslf_accum, lslf_queue, lslf_solve
//
//   channel  handshake             payload
//   in       in_valid / in_ready   in_x_value, in_y_value, in_last_point
//   out      out_valid / out_ready out_slope, out_intercept, out_fit_status
//
// points are taken one per cycle; the ready only drops while two finished
// sets already wait in the queue ahead of the solver
// the solver works on one set at a time, through the bit-serial multiplier
// and the one-bit-a-cycle divider; sets with zero x variance stop after the
// first two products, sets with too many points go straight to the output;
// a result waiting on out_ready holds the solver
// synchronous active-low reset clears the sums, queue and sequencer

module least_squares_line_fit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lslf_pkg::SAMPLE_W-1:0] in_x_value,
  input  logic [lslf_pkg::SAMPLE_W-1:0] in_y_value,
  input  logic                          in_last_point,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lslf_pkg::OUT_W-1:0]    out_slope,
  output logic [lslf_pkg::OUT_W-1:0]    out_intercept,
  output logic [lslf_pkg::STATUS_W-1:0] out_fit_status
);
  import lslf_pkg::*;

  logic  q_ready;
  logic  q_push;
  snap_t q_wdata;
  logic  q_valid;
  logic  q_pop;
  snap_t q_rdata;

  lslf_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_x_value    (in_x_value),
    .in_y_value    (in_y_value),
    .in_last_point (in_last_point),
    .q_ready       (q_ready),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  lslf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .ready (q_ready),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  lslf_solve u_solve (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_slope      (out_slope),
    .out_intercept  (out_intercept),
    .out_fit_status (out_fit_status)
  );

endmodule
